// File: rtl/core/wmrd_pkg.sv
// ----------------------------------------------------------------------------
// wmrd_pkg
// shared constants, types and register indexes of the windowed motion rest
// detector
// ----------------------------------------------------------------------------
package wmrd_pkg;

    localparam int WINDOW    = 16;
    localparam int SLOT_W    = $clog2(WINDOW);
    localparam int COUNT_W   = $clog2(WINDOW + 1);
    localparam int DATA_W    = 32;
    localparam int SUM_W     = DATA_W + SLOT_W;
    localparam int SQ_W      = 2 * DATA_W;

    localparam int DIST_LIMIT_W  = 63;
    localparam int ANGLE_LIMIT_W = 31;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 63;

    localparam logic [DIST_LIMIT_W-1:0]  DIST_LIMIT_RESET  = 63'd17179869184;
    localparam logic [ANGLE_LIMIT_W-1:0] ANGLE_LIMIT_RESET = 31'd655;

    localparam logic [CFG_IDX_W-1:0] REG_DIST_SQ_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_LIMIT   = 2'd1;

    localparam logic MODE_SAMPLE  = 1'b0;
    localparam logic MODE_RESTART = 1'b1;

    typedef logic signed [DATA_W-1:0] data_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    // one pose as it travels from the input register into the window stage
    typedef struct packed {
        logic  mode;
        data_t pos_x;
        data_t pos_y;
        data_t angle;
    } wmrd_pose_t;

    // control travelling alongside the sums into the evaluation stages
    typedef struct packed {
        logic valid;
        logic full;
    } wmrd_ctl_t;

    // magnitude of a signed sum, fits unsigned in the same width
    function automatic logic [SUM_W-1:0] sum_mag(input sum_t v);
        logic [SUM_W-1:0] u;
        begin
            u = v;
            sum_mag = v[SUM_W-1] ? (~u + 1'b1) : u;
        end
    endfunction

endpackage

// File: rtl/core/wmrd_drift_window.sv
// ----------------------------------------------------------------------------
// wmrd_drift_window
// pose deltas, delta ring and running drift sums, one pose per cycle while en is high
// ----------------------------------------------------------------------------
module wmrd_drift_window (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                pose_valid,
    input  wmrd_pkg::wmrd_pose_t pose,
    output wmrd_pkg::sum_t      sum_dx,
    output wmrd_pkg::sum_t      sum_dy,
    output wmrd_pkg::sum_t      sum_dangle,
    output wmrd_pkg::wmrd_ctl_t ctl
);

    wmrd_pkg::data_t prev_x_reg, prev_y_reg, prev_a_reg;
    wmrd_pkg::sum_t  sum_dx_reg, sum_dy_reg, sum_da_reg;
    wmrd_pkg::sum_t  sum_dx_next, sum_dy_next, sum_da_next;
    logic [wmrd_pkg::SLOT_W-1:0]  write_slot_reg, write_slot_next;
    logic [wmrd_pkg::COUNT_W-1:0] fill_count_reg, fill_count_next;
    wmrd_pkg::wmrd_ctl_t          ctl_reg, ctl_next;

    wmrd_pkg::data_t ring_dx [wmrd_pkg::WINDOW];
    wmrd_pkg::data_t ring_dy [wmrd_pkg::WINDOW];
    wmrd_pkg::data_t ring_da [wmrd_pkg::WINDOW];

    wmrd_pkg::data_t dx, dy, da;
    wmrd_pkg::data_t old_dx, old_dy, old_da;
    logic [wmrd_pkg::SLOT_W-1:0] slot;
    logic filling;
    logic step;
    logic ring_we;

    // deltas wrap modulo 2^32
    assign dx = pose.pos_x - prev_x_reg;
    assign dy = pose.pos_y - prev_y_reg;
    assign da = pose.angle - prev_a_reg;

    assign filling = (fill_count_reg < wmrd_pkg::COUNT_W'(wmrd_pkg::WINDOW));
    assign slot    = filling ? fill_count_reg[wmrd_pkg::SLOT_W-1:0] : write_slot_reg;
    assign step    = en && pose_valid;
    assign ring_we = step && (pose.mode == wmrd_pkg::MODE_SAMPLE);

    assign old_dx = ring_dx[slot];
    assign old_dy = ring_dy[slot];
    assign old_da = ring_da[slot];

    always_comb
    begin
        sum_dx_next     = sum_dx_reg;
        sum_dy_next     = sum_dy_reg;
        sum_da_next     = sum_da_reg;
        write_slot_next = write_slot_reg;
        fill_count_next = fill_count_reg;
        ctl_next        = ctl_reg;
        if (en)
        begin
            ctl_next.valid = pose_valid;
            ctl_next.full  = 1'b0;
        end
        if (step)
        begin
            if (pose.mode == wmrd_pkg::MODE_RESTART)
            begin
                sum_dx_next     = '0;
                sum_dy_next     = '0;
                sum_da_next     = '0;
                write_slot_next = '0;
                fill_count_next = '0;
            end
            else if (filling)
            begin
                sum_dx_next     = sum_dx_reg + wmrd_pkg::SUM_W'(dx);
                sum_dy_next     = sum_dy_reg + wmrd_pkg::SUM_W'(dy);
                sum_da_next     = sum_da_reg + wmrd_pkg::SUM_W'(da);
                fill_count_next = fill_count_reg + 1'b1;
            end
            else
            begin
                sum_dx_next = sum_dx_reg - wmrd_pkg::SUM_W'(old_dx) + wmrd_pkg::SUM_W'(dx);
                sum_dy_next = sum_dy_reg - wmrd_pkg::SUM_W'(old_dy) + wmrd_pkg::SUM_W'(dy);
                sum_da_next = sum_da_reg - wmrd_pkg::SUM_W'(old_da) + wmrd_pkg::SUM_W'(da);
                write_slot_next = (write_slot_reg == wmrd_pkg::SLOT_W'(wmrd_pkg::WINDOW - 1))
                                  ? '0 : write_slot_reg + 1'b1;
                ctl_next.full   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            prev_a_reg     <= '0;
            sum_dx_reg     <= '0;
            sum_dy_reg     <= '0;
            sum_da_reg     <= '0;
            write_slot_reg <= '0;
            fill_count_reg <= '0;
            ctl_reg        <= '0;
        end
        else
        begin
            if (step)
            begin
                prev_x_reg <= pose.pos_x;
                prev_y_reg <= pose.pos_y;
                prev_a_reg <= pose.angle;
            end
            sum_dx_reg     <= sum_dx_next;
            sum_dy_reg     <= sum_dy_next;
            sum_da_reg     <= sum_da_next;
            write_slot_reg <= write_slot_next;
            fill_count_reg <= fill_count_next;
            ctl_reg        <= ctl_next;
        end
    end

    // delta ring, contents undefined until written
    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring_dx[slot] <= dx;
            ring_dy[slot] <= dy;
            ring_da[slot] <= da;
        end
    end

    assign sum_dx     = sum_dx_reg;
    assign sum_dy     = sum_dy_reg;
    assign sum_dangle = sum_da_reg;
    assign ctl        = ctl_reg;

endmodule

// File: rtl/core/wmrd_rest_eval.sv
// ----------------------------------------------------------------------------
// wmrd_rest_eval
// saturating squared drift and angle check against the rest limits
// ----------------------------------------------------------------------------
module wmrd_rest_eval (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  wmrd_pkg::sum_t                      sum_dx,
    input  wmrd_pkg::sum_t                      sum_dy,
    input  wmrd_pkg::sum_t                      sum_dangle,
    input  wmrd_pkg::wmrd_ctl_t                 ctl,
    input  logic [wmrd_pkg::DIST_LIMIT_W-1:0]   dist_sq_limit,
    input  logic [wmrd_pkg::ANGLE_LIMIT_W-1:0]  angle_limit,
    output logic                                rest_valid,
    output logic                                rest
);

    logic [wmrd_pkg::SUM_W-1:0]  mag_x, mag_y, mag_a;
    logic [wmrd_pkg::SQ_W-1:0]   sq_x_next, sq_y_next;
    logic [wmrd_pkg::SQ_W-1:0]   sq_x_reg, sq_y_reg;
    logic                        ang_ok_next, ang_ok_reg;
    wmrd_pkg::wmrd_ctl_t         ctl_reg;
    logic [wmrd_pkg::SQ_W:0]     sq_sum;
    logic [wmrd_pkg::SQ_W-1:0]   sq_total;

    assign mag_x = wmrd_pkg::sum_mag(sum_dx);
    assign mag_y = wmrd_pkg::sum_mag(sum_dy);
    assign mag_a = wmrd_pkg::sum_mag(sum_dangle);

    // a magnitude of 2^32 or more saturates its square
    always_comb
    begin
        if (mag_x[wmrd_pkg::SUM_W-1:wmrd_pkg::DATA_W] != '0)
            sq_x_next = '1;
        else
            sq_x_next = mag_x[wmrd_pkg::DATA_W-1:0] * mag_x[wmrd_pkg::DATA_W-1:0];
        if (mag_y[wmrd_pkg::SUM_W-1:wmrd_pkg::DATA_W] != '0)
            sq_y_next = '1;
        else
            sq_y_next = mag_y[wmrd_pkg::DATA_W-1:0] * mag_y[wmrd_pkg::DATA_W-1:0];
    end

    assign ang_ok_next = ({1'b0, mag_a} < (wmrd_pkg::SUM_W + 1)'(angle_limit));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_x_reg   <= sq_x_next;
            sq_y_reg   <= sq_y_next;
            ang_ok_reg <= ang_ok_next;
        end
    end

    assign sq_sum   = {1'b0, sq_x_reg} + {1'b0, sq_y_reg};
    assign sq_total = sq_sum[wmrd_pkg::SQ_W] ? '1 : sq_sum[wmrd_pkg::SQ_W-1:0];

    assign rest_valid = ctl_reg.valid;
    assign rest       = ctl_reg.full && ang_ok_reg
                        && (sq_total < wmrd_pkg::SQ_W'(dist_sq_limit));

endmodule

// File: rtl/core/windowed_motion_rest_detector_unit.sv
// ----------------------------------------------------------------------------
// windowed_motion_rest_detector_unit
// sliding-window drift sum rest detector for a 2d body pose
// ----------------------------------------------------------------------------
// Takes one pose (x, y, angle, signed Q16.16) per transaction and returns one
// at_rest flag per transaction, in order. A pose may be accepted every clock
// while the result register is not held back; the result passes the input
// register, window update, squaring stage and result register. While the
// output is stalled the input register still takes one further transaction.
// Mode 1 restarts the detector at the given pose; mode 0 adds the pose
// deltas to a ring of WINDOW entries. The flag stays low until the ring is
// full, then it is high when the squared summed position drift (saturating
// Q32.32) is below dist_sq_limit and the absolute summed angle drift is
// below angle_limit, both strictly. The user must write limits through the
// cfg port only while idle; the block does not enforce this. Writes to unused
// indexes are dropped. No clearing pass after reset.
module windowed_motion_rest_detector_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    // configuration write port
    input  logic                               cfg_we,
    input  logic [wmrd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [wmrd_pkg::CFG_DATA_W-1:0]    cfg_data,
    // pose channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               mode,
    input  logic signed [wmrd_pkg::DATA_W-1:0] pos_x,
    input  logic signed [wmrd_pkg::DATA_W-1:0] pos_y,
    input  logic signed [wmrd_pkg::DATA_W-1:0] angle,
    // result channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               at_rest
);

    // rest limits
    logic [wmrd_pkg::DIST_LIMIT_W-1:0]  dist_sq_limit_reg;
    logic [wmrd_pkg::ANGLE_LIMIT_W-1:0] angle_limit_reg;

    // input register
    logic                 in_valid_reg, in_valid_next;
    wmrd_pkg::wmrd_pose_t pose_reg;
    logic                 in_take;

    // result register
    logic out_valid_reg;
    logic at_rest_reg;

    // pipeline advance: whole pipe moves unless a result is held back
    logic en;

    wmrd_pkg::sum_t      sum_dx, sum_dy, sum_dangle;
    wmrd_pkg::wmrd_ctl_t win_ctl;
    logic                rest_valid, rest;

    assign en       = !out_valid_reg || out_ready;
    // input register free, or its pose moves on this cycle
    assign in_ready = !in_valid_reg || en;
    assign in_take  = in_valid && in_ready;

    assign in_valid_next = in_take ? 1'b1 : (en ? 1'b0 : in_valid_reg);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_sq_limit_reg <= wmrd_pkg::DIST_LIMIT_RESET;
            angle_limit_reg   <= wmrd_pkg::ANGLE_LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                wmrd_pkg::REG_DIST_SQ_LIMIT:
                begin
                    dist_sq_limit_reg <= cfg_data[wmrd_pkg::DIST_LIMIT_W-1:0];
                end
                wmrd_pkg::REG_ANGLE_LIMIT:
                begin
                    angle_limit_reg <= cfg_data[wmrd_pkg::ANGLE_LIMIT_W-1:0];
                end
                default:
                begin
                    // unused index, write dropped
                end
            endcase
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pose_reg.mode  <= mode;
            pose_reg.pos_x <= pos_x;
            pose_reg.pos_y <= pos_y;
            pose_reg.angle <= angle;
        end
    end

    // deltas, ring and running sums
    wmrd_drift_window u_window (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (en),
        .pose_valid (in_valid_reg),
        .pose       (pose_reg),
        .sum_dx     (sum_dx),
        .sum_dy     (sum_dy),
        .sum_dangle (sum_dangle),
        .ctl        (win_ctl)
    );

    // squares and limit compares
    wmrd_rest_eval u_eval (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .sum_dx        (sum_dx),
        .sum_dy        (sum_dy),
        .sum_dangle    (sum_dangle),
        .ctl           (win_ctl),
        .dist_sq_limit (dist_sq_limit_reg),
        .angle_limit   (angle_limit_reg),
        .rest_valid    (rest_valid),
        .rest          (rest)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= rest_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            at_rest_reg <= rest;
        end
    end

    assign out_valid = out_valid_reg;
    assign at_rest   = at_rest_reg;

endmodule

// File: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking testbench for the windowed motion rest detector
// ----------------------------------------------------------------------------
// Drives pose transactions into the detector with random gaps and checks
// every at_rest flag against a cycle-free predictor of the drift window. A
// short directed run covers the field extremes, both modes and saturated
// drift. It is followed by phases of random tracks, each phase with its own
// limits: still and jittery tracks, tracks that sit on or next to the limits,
// and raw noise. The result side stalls at random and once holds off long
// enough for the detector to back up into its input.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wmrd_pkg::*;

    localparam int GAP_MAX         = 16;
    localparam int HOLD_OFF_AT     = 250;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_PAD       = 8;
    localparam int NUM_PHASES      = 7;
    localparam int PHASE_ITEMS     = 110;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    localparam logic [DATA_W-1:0] POS_MIN  = 32'h8000_0000;
    localparam logic [DATA_W-1:0] POS_MAX  = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] EDGE_MAX = 32'h7FFF_FFFE;

    // ------------------------------------------------------------------------
    // predictor of the drift window and store of the flags still owed
    // ------------------------------------------------------------------------
    class rest_flag_scoreboard;
        logic [DIST_LIMIT_W-1:0]  dist_lim;
        logic [ANGLE_LIMIT_W-1:0] ang_lim;
        logic signed [DATA_W-1:0] ring_dx [WINDOW];
        logic signed [DATA_W-1:0] ring_dy [WINDOW];
        logic signed [DATA_W-1:0] ring_da [WINDOW];
        longint                   sum_dx, sum_dy, sum_da;
        logic [DATA_W-1:0]        last_x, last_y, last_a;
        int                       slot, filled;
        bit                       expected_flags [$];
        int                       mismatches;

        function new();
            dist_lim   = DIST_LIMIT_RESET;
            ang_lim    = ANGLE_LIMIT_RESET;
            mismatches = 0;
            rearm('0, '0, '0);
        endfunction

        function void rearm(input logic [DATA_W-1:0] x, y, a);
            last_x = x;
            last_y = y;
            last_a = a;
            sum_dx = 0;
            sum_dy = 0;
            sum_da = 0;
            slot   = 0;
            filled = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] val);
            if (idx == REG_DIST_SQ_LIMIT)
                dist_lim = val[DIST_LIMIT_W-1:0];
            else if (idx == REG_ANGLE_LIMIT)
                ang_lim = val[ANGLE_LIMIT_W-1:0];
        endfunction

        function logic [63:0] sat_square(input longint v);
            logic [63:0] m;
            m = (v < 0) ? -v : v;
            if (m >= 64'h1_0000_0000)
                return '1;
            return m * m;
        endfunction

        function void note_pose(input logic m, input logic [DATA_W-1:0] x, y, a);
            logic signed [DATA_W-1:0] dx, dy, da;
            logic [64:0]              total;
            logic [63:0]              drift_sq;
            longint                   ang_mag;
            dx = x - last_x;
            dy = y - last_y;
            da = a - last_a;
            if (m == MODE_RESTART) begin
                rearm(x, y, a);
                expected_flags.push_back(1'b0);
                return;
            end
            last_x = x;
            last_y = y;
            last_a = a;
            if (filled < WINDOW) begin
                ring_dx[filled] = dx;
                ring_dy[filled] = dy;
                ring_da[filled] = da;
                sum_dx += dx;
                sum_dy += dy;
                sum_da += da;
                filled++;
                expected_flags.push_back(1'b0);
                return;
            end
            sum_dx = sum_dx - ring_dx[slot] + dx;
            sum_dy = sum_dy - ring_dy[slot] + dy;
            sum_da = sum_da - ring_da[slot] + da;
            ring_dx[slot] = dx;
            ring_dy[slot] = dy;
            ring_da[slot] = da;
            slot = (slot == WINDOW - 1) ? 0 : slot + 1;
            total    = {1'b0, sat_square(sum_dx)} + {1'b0, sat_square(sum_dy)};
            drift_sq = total[64] ? '1 : total[63:0];
            ang_mag  = (sum_da < 0) ? -sum_da : sum_da;
            expected_flags.push_back(drift_sq < 64'(dist_lim) &&
                                     ang_mag < longint'(ang_lim));
        endfunction

        function void check_flag(input logic got);
            bit want;
            if (expected_flags.size() == 0) begin
                $display("%0t: unexpected at_rest %b, expected none", $time, got);
                mismatches++;
                return;
            end
            want = expected_flags.pop_front();
            if (got !== want) begin
                $display("%0t: at_rest mismatch, expected %b, actual %b",
                         $time, want, got);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_flags.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals and the block under test
    // ------------------------------------------------------------------------
    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic                  mode;
    logic signed [DATA_W-1:0] pos_x, pos_y, angle;
    logic                  out_valid;
    logic                  out_ready;
    logic                  at_rest;

    rest_flag_scoreboard sb = new();

    // last pose handed over, the base for the next track step
    logic [DATA_W-1:0] cur_x = '0, cur_y = '0, cur_a = '0;
    int                items_sent = 0;
    int                flags_taken = 0;
    bit                send_burst = 1'b0;
    bit                take_burst = 1'b0;
    int                stall_cycles = 0;

    windowed_motion_rest_detector_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .angle     (angle),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .at_rest   (at_rest)
    );

    always #5 clk = ~clk;

    // watchdog: a long run of cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // helpers for the stimulus
    // ------------------------------------------------------------------------
    // jitter amplitude, from dead still up to the full field range
    function automatic int unsigned pick_amp();
        case ($urandom_range(0, 4))
            0:       return 0;
            1:       return $urandom_range(1, 64);
            2:       return $urandom_range(1, 32'h1000);
            3:       return $urandom_range(1, 32'h10_0000);
            default: return 32'h7FFF_FFFF;
        endcase
    endfunction

    function automatic logic [DATA_W-1:0] rand_delta(input int unsigned amp);
        longint r;
        r = longint'($urandom_range(0, 2 * amp)) - longint'(amp);
        return r[DATA_W-1:0];
    endfunction

    // limit magnitude for a phase, small, medium or close to full range
    function automatic logic [DATA_W-1:0] pick_edge_mag();
        case ($urandom_range(0, 2))
            0:       return $urandom_range(1, 32'h3FF);
            1:       return $urandom_range(1, 32'hF_FFFF);
            default: return $urandom_range(1, EDGE_MAX);
        endcase
    endfunction

    // one below, on, or one above a limit magnitude
    function automatic logic [DATA_W-1:0] near_mag(input logic [DATA_W-1:0] v);
        case ($urandom_range(0, 2))
            0:       return (v == 0) ? v : v - 1;
            1:       return v;
            default: return v + 1;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // driving tasks
    // ------------------------------------------------------------------------
    task automatic send_pose(input logic m, input logic [DATA_W-1:0] x, y, a);
        int gap;
        if ($urandom_range(0, 31) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, GAP_MAX);
        if (gap > 0)
        begin
            // idle with junk on the payload
            in_valid <= 1'b0;
            mode     <= $urandom_range(0, 1);
            pos_x    <= $urandom;
            pos_y    <= $urandom;
            angle    <= $urandom;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode     <= m;
        pos_x    <= x;
        pos_y    <= y;
        angle    <= a;
        do @(posedge clk); while (!in_ready);
        sb.note_pose(m, x, y, a);
        cur_x = x;
        cur_y = y;
        cur_a = a;
        items_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
        @(posedge clk);
    endtask

    // stop offering and let every owed flag come out
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_PAD) @(posedge clk);
    endtask

    // restart or carry on, then a track of small or large random steps
    task automatic jitter_track(input int n);
        int unsigned amp_xy, amp_a;
        amp_xy = pick_amp();
        amp_a  = pick_amp();
        if ($urandom_range(0, 9) < 7)
        begin
            if ($urandom_range(0, 1))
                send_pose(MODE_RESTART, $urandom, $urandom, $urandom);
            else
                send_pose(MODE_RESTART, cur_x, cur_y, cur_a);
        end
        repeat (n)
            send_pose(MODE_SAMPLE, cur_x + rand_delta(amp_xy),
                      cur_y + rand_delta(amp_xy), cur_a + rand_delta(amp_a));
    endtask

    // still window, then one step that puts the summed drift on or next to a limit
    task automatic edge_track(input logic [DATA_W-1:0] em, ae);
        logic [DATA_W-1:0] bx, by, ba, d, da;
        bx = $urandom;
        by = $urandom;
        ba = $urandom;
        send_pose(MODE_RESTART, bx, by, ba);
        repeat (WINDOW) send_pose(MODE_SAMPLE, bx, by, ba);
        d  = near_mag(em);
        da = ($urandom_range(0, 3) == 0) ? '0 : near_mag(ae);
        if ($urandom_range(0, 1))
            d = -d;
        if ($urandom_range(0, 1))
            da = -da;
        if ($urandom_range(0, 1))
            bx = bx + d;
        else
            by = by + d;
        ba = ba + da;
        repeat ($urandom_range(1, 20)) send_pose(MODE_SAMPLE, bx, by, ba);
    endtask

    task automatic noise_burst(input int n);
        repeat (n)
            send_pose(($urandom_range(0, 7) == 0) ? MODE_RESTART : MODE_SAMPLE,
                      $urandom, $urandom, $urandom);
    endtask

    // ------------------------------------------------------------------------
    // result side: random stalls, one long hold-off to back the block up
    // ------------------------------------------------------------------------
    initial
    begin : flag_sink
        int gap;
        out_ready <= 1'b0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (flags_taken == HOLD_OFF_AT)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            if ($urandom_range(0, 31) == 0)
                take_burst = !take_burst;
            gap = take_burst ? 0 : $urandom_range(0, GAP_MAX);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_flag(at_rest);
            flags_taken++;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        logic [DATA_W-1:0] em, ae;
        logic [63:0]       em64;
        int                target;
        int                pick;

        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        mode      <= MODE_SAMPLE;
        pos_x     <= '0;
        pos_y     <= '0;
        angle     <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // writes to unused indexes must leave the reset limits alone
        write_reg(REG_SPARE_A, '0);
        write_reg(REG_SPARE_B, '0);

        // directed: restart, then a window of the largest possible deltas
        // so that the sums reach their full width and the square saturates
        send_pose(MODE_RESTART, '0, '0, '0);
        for (int i = 0; i < WINDOW + 2; i++)
            send_pose(MODE_SAMPLE, (i % 2 == 0) ? POS_MIN : 32'd0,
                      (i % 2 == 0) ? POS_MIN : 32'd0, cur_a + POS_MAX);
        send_pose(MODE_RESTART, POS_MAX, POS_MAX, POS_MIN);
        send_pose(MODE_SAMPLE, POS_MIN, POS_MIN, POS_MAX);

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_idle();
            case (p)
                0:
                begin
                    // reset limits, edge of 2.0 in position and 655 in angle
                    em = 32'h0002_0000;
                    ae = ANGLE_LIMIT_RESET;
                end
                1:
                begin
                    // nothing can ever be at rest
                    em = '0;
                    ae = '0;
                    write_reg(REG_DIST_SQ_LIMIT, '0);
                    write_reg(REG_ANGLE_LIMIT, '0);
                end
                2:
                begin
                    // widest limits, high bits of the angle write dropped
                    em = EDGE_MAX;
                    ae = EDGE_MAX;
                    write_reg(REG_DIST_SQ_LIMIT, '1);
                    write_reg(REG_ANGLE_LIMIT, '1);
                end
                default:
                begin
                    em   = pick_edge_mag();
                    ae   = pick_edge_mag();
                    em64 = em;
                    if ($urandom_range(0, 3) == 0)
                    begin
                        write_reg(REG_DIST_SQ_LIMIT, CFG_DATA_W'({$urandom, $urandom}));
                        write_reg(REG_ANGLE_LIMIT, CFG_DATA_W'({$urandom, $urandom}));
                    end
                    else
                    begin
                        write_reg(REG_DIST_SQ_LIMIT, CFG_DATA_W'(em64 * em64));
                        write_reg(REG_ANGLE_LIMIT, CFG_DATA_W'(ae));
                    end
                end
            endcase
            if (p > 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B,
                          CFG_DATA_W'({$urandom, $urandom}));

            // every phase opens on its limit edge, then mixed tracks
            target = items_sent + PHASE_ITEMS;
            edge_track(em, ae);
            while (items_sent < target)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 5)
                    jitter_track($urandom_range(WINDOW, 3 * WINDOW));
                else if (pick < 8)
                    edge_track(em, ae);
                else
                    noise_burst($urandom_range(1, 8));
            end
        end

        wait_idle();
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
